// ===== rtl/slsp_pkg.sv =====
package slsp_pkg;

  // default sizes
  localparam int MAX_TASKS_DEF = 1024;
  localparam int MAX_PROCS_DEF = 64;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int TIDX_W = 10;
  localparam int PIDX_W = 6;
  localparam int WT_W   = 32;
  localparam int ST_W   = 2;
  localparam int LOAD_W = 42;

  // wide enough to compare any in-use count with any index
  localparam int CMP_W = 17;

  // configuration registers
  localparam int PROCS_W = 7;
  localparam int TASKS_W = 11;
  localparam logic [PROCS_W-1:0] PROCS_RESET = 7'd64;
  localparam logic [TASKS_W-1:0] TASKS_RESET = 11'd1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] STAT_OK         = 2'd0;
  localparam logic [ST_W-1:0] STAT_BAD_TASK   = 2'd1;
  localparam logic [ST_W-1:0] STAT_BAD_PROC   = 2'd2;
  localparam logic [ST_W-1:0] STAT_NOT_LOADED = 2'd3;

  typedef struct packed {
    logic [CMP_W-1:0] used_procs;
    logic [CMP_W-1:0] used_tasks;
    logic             wr;
  } cfg_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [LOAD_W-1:0] spread;
  } res_t;

endpackage

// ===== rtl/slsp_ram.sv =====
module slsp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read before write on a shared address
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/slsp_apb_regs.sv =====
module slsp_apb_regs #(
  parameter int MAX_TASKS = slsp_pkg::MAX_TASKS_DEF,
  parameter int MAX_PROCS = slsp_pkg::MAX_PROCS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output slsp_pkg::cfg_t      cfg_o
);

  localparam logic REG_PROCS = 1'b0;
  localparam logic REG_TASKS = 1'b1;
  localparam int   CW        = slsp_pkg::CMP_W;

  logic [slsp_pkg::PROCS_W-1:0] procs_q;
  logic [slsp_pkg::TASKS_W-1:0] tasks_q;
  logic                         wr;
  logic [CW-1:0]                procs_ext;
  logic [CW-1:0]                tasks_ext;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_q <= slsp_pkg::PROCS_RESET;
      tasks_q <= slsp_pkg::TASKS_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_PROCS: procs_q <= pwdata[slsp_pkg::PROCS_W-1:0];
        REG_TASKS: tasks_q <= pwdata[slsp_pkg::TASKS_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PROCS: prdata = 32'(procs_q);
      REG_TASKS: prdata = 32'(tasks_q);
      default:   prdata = '0;
    endcase
  end

  // in-use counts clamped to 1..max
  assign procs_ext = CW'(procs_q);
  assign tasks_ext = CW'(tasks_q);

  always_comb begin
    priority if (procs_q == '0) begin
      cfg_o.used_procs = CW'(1);
    end else if (procs_ext > CW'(MAX_PROCS)) begin
      cfg_o.used_procs = CW'(MAX_PROCS);
    end else begin
      cfg_o.used_procs = procs_ext;
    end
    priority if (tasks_q == '0) begin
      cfg_o.used_tasks = CW'(1);
    end else if (tasks_ext > CW'(MAX_TASKS)) begin
      cfg_o.used_tasks = CW'(MAX_TASKS);
    end else begin
      cfg_o.used_tasks = tasks_ext;
    end
    cfg_o.wr = wr;
  end

endmodule

// ===== rtl/slsp_seq.sv =====
module slsp_seq #(
  parameter int MAX_TASKS = slsp_pkg::MAX_TASKS_DEF,
  parameter int MAX_PROCS = slsp_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = slsp_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slsp_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [slsp_pkg::OP_W-1:0]     operation_i,
  input  logic [slsp_pkg::TIDX_W-1:0]   task_index_i,
  input  logic [slsp_pkg::PIDX_W-1:0]   target_proc_i,
  input  logic [slsp_pkg::WT_W-1:0]     work_time_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output slsp_pkg::res_t                res_o
);

  localparam int TW    = $clog2(MAX_TASKS);
  localparam int PW    = $clog2(MAX_PROCS);
  localparam int PCW   = $clog2(MAX_PROCS + 1);
  localparam int CLR_N = (MAX_TASKS > MAX_PROCS) ? MAX_TASKS : MAX_PROCS;
  localparam int CLW   = $clog2(CLR_N);
  localparam int CLW1  = CLW + 1;
  localparam int TMW   = 1 + PW + TIME_BITS;
  localparam int LW    = slsp_pkg::LOAD_W;
  localparam int CW    = slsp_pkg::CMP_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TASK,
    S_SUB,
    S_ADD,
    S_SCAN,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [CLW-1:0]      clr_cnt_q;
  logic [TW-1:0]       task_q;
  logic [PW-1:0]       proc_q;
  logic [TIME_BITS-1:0] time_q;
  logic                is_load_q;
  logic [PW-1:0]       old_proc_q;
  logic [LW-1:0]       oldt_q;
  logic [LW-1:0]       amt_q;
  logic [LW-1:0]       fwd_q;
  logic                same_q;
  logic                cache_valid_q;
  logic [LW-1:0]       cached_q;
  logic [PCW-1:0]      scan_cnt_q;
  logic                rv_q;
  logic                first_q;
  logic [LW-1:0]       lo_q;
  logic [LW-1:0]       hi_q;
  slsp_pkg::res_t      res_q;

  // task memory word: loaded, processor, time
  logic                 tm_we;
  logic [TW-1:0]        tm_waddr;
  logic [TMW-1:0]       tm_wdata;
  logic [TMW-1:0]       tm_rdata;
  logic                 tm_loaded;
  logic [PW-1:0]        tm_proc;
  logic [TIME_BITS-1:0] tm_time;
  logic [TIME_BITS-1:0] new_time;

  logic                 pm_we;
  logic [PW-1:0]        pm_waddr;
  logic [LW-1:0]        pm_wdata;
  logic [PW-1:0]        pm_raddr;
  logic [LW-1:0]        pm_rdata;
  logic [LW-1:0]        sub_val;
  logic [LW-1:0]        add_val;

  logic                 accept;
  logic                 bad_task;
  logic                 bad_proc;
  logic                 scan_rd;
  logic                 clr_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  assign bad_task = CW'(task_index_i) >= cfg_i.used_tasks;
  assign bad_proc = CW'(target_proc_i) >= cfg_i.used_procs;

  assign tm_loaded = tm_rdata[TMW-1];
  assign tm_proc   = tm_rdata[TIME_BITS +: PW];
  assign tm_time   = tm_rdata[TIME_BITS-1:0];
  assign new_time  = is_load_q ? time_q : tm_time;

  assign sub_val  = pm_rdata - oldt_q;
  assign add_val  = (same_q ? fwd_q : pm_rdata) + amt_q;
  assign scan_rd  = CW'(scan_cnt_q) < cfg_i.used_procs;
  assign clr_last = clr_cnt_q == CLW'(CLR_N - 1);

  slsp_ram #(
    .DEPTH(MAX_TASKS),
    .WIDTH(TMW)
  ) u_task_mem (
    .clk_i  (clk_i),
    .we_i   (tm_we),
    .waddr_i(tm_waddr),
    .wdata_i(tm_wdata),
    .raddr_i(TW'(task_index_i)),
    .rdata_o(tm_rdata)
  );

  slsp_ram #(
    .DEPTH(MAX_PROCS),
    .WIDTH(LW)
  ) u_load_mem (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wdata_i(pm_wdata),
    .raddr_i(pm_raddr),
    .rdata_o(pm_rdata)
  );

  always_comb begin
    tm_we    = 1'b0;
    tm_waddr = clr_cnt_q[TW-1:0];
    tm_wdata = '0;
    pm_we    = 1'b0;
    pm_waddr = clr_cnt_q[PW-1:0];
    pm_wdata = '0;
    pm_raddr = scan_cnt_q[PW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        tm_we = {1'b0, clr_cnt_q} < CLW1'(MAX_TASKS);
        pm_we = {1'b0, clr_cnt_q} < CLW1'(MAX_PROCS);
      end
      S_TASK: begin
        if (is_load_q || tm_loaded) begin
          tm_we    = 1'b1;
          tm_waddr = task_q;
          tm_wdata = {1'b1, proc_q, new_time};
        end
        pm_raddr = tm_loaded ? tm_proc : proc_q;
      end
      S_SUB: begin
        pm_we    = 1'b1;
        pm_waddr = old_proc_q;
        pm_wdata = sub_val;
        pm_raddr = proc_q;
      end
      S_ADD: begin
        pm_we    = 1'b1;
        pm_waddr = proc_q;
        pm_wdata = add_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      cache_valid_q <= 1'b0;
      cached_q      <= '0;
      rv_q          <= 1'b0;
      first_q       <= 1'b0;
      scan_cnt_q    <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + CLW'(1);
          if (clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            task_q    <= TW'(task_index_i);
            proc_q    <= PW'(target_proc_i);
            time_q    <= TIME_BITS'(work_time_i);
            is_load_q <= operation_i == slsp_pkg::OP_LOAD;
            priority if (operation_i == slsp_pkg::OP_LOAD ||
                         operation_i == slsp_pkg::OP_MOVE) begin
              res_q.spread <= '0;
              priority if (bad_task) begin
                res_q.status <= slsp_pkg::STAT_BAD_TASK;
                state_q      <= S_DONE;
              end else if (bad_proc) begin
                res_q.status <= slsp_pkg::STAT_BAD_PROC;
                state_q      <= S_DONE;
              end else begin
                res_q.status <= slsp_pkg::STAT_OK;
                state_q      <= S_TASK;
              end
            end else if (operation_i == slsp_pkg::OP_EVAL) begin
              res_q.status <= slsp_pkg::STAT_OK;
              if (cache_valid_q) begin
                res_q.spread <= cached_q;
                state_q      <= S_DONE;
              end else begin
                scan_cnt_q <= '0;
                rv_q       <= 1'b0;
                first_q    <= 1'b1;
                state_q    <= S_SCAN;
              end
            end else begin
              res_q.status <= slsp_pkg::STAT_OK;
              res_q.spread <= '0;
              state_q      <= S_DONE;
            end
          end
        end
        S_TASK: begin
          if (!is_load_q && !tm_loaded) begin
            res_q.status <= slsp_pkg::STAT_NOT_LOADED;
            state_q      <= S_DONE;
          end else begin
            amt_q         <= LW'(new_time);
            oldt_q        <= LW'(tm_time);
            old_proc_q    <= tm_proc;
            same_q        <= 1'b0;
            cache_valid_q <= 1'b0;
            state_q       <= tm_loaded ? S_SUB : S_ADD;
          end
        end
        S_SUB: begin
          // old entry written while target is read; forward when they match
          fwd_q   <= sub_val;
          same_q  <= old_proc_q == proc_q;
          state_q <= S_ADD;
        end
        S_ADD: begin
          state_q <= S_DONE;
        end
        S_SCAN: begin
          rv_q <= scan_rd;
          if (scan_rd) begin
            scan_cnt_q <= scan_cnt_q + PCW'(1);
          end
          if (rv_q) begin
            first_q <= 1'b0;
            if (first_q || pm_rdata < lo_q) begin
              lo_q <= pm_rdata;
            end
            if (first_q || pm_rdata > hi_q) begin
              hi_q <= pm_rdata;
            end
          end
          if (!scan_rd && !rv_q) begin
            cached_q      <= hi_q - lo_q;
            cache_valid_q <= 1'b1;
            res_q.spread  <= hi_q - lo_q;
            state_q       <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
      if (cfg_i.wr) begin
        cache_valid_q <= 1'b0;
      end
    end
  end

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !clr_last) |=> state_q == S_CLEAR)
    else $error("clearing pass left early");

  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !first_q) |-> hi_q >= lo_q)
    else $error("scan maximum below minimum");

  a_cache_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !scan_rd && !rv_q) |=> (cache_valid_q || $past(cfg_i.wr)))
    else $error("finished scan did not fill the cache");

  a_add_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD |-> ($past(state_q) == S_TASK || $past(state_q) == S_SUB))
    else $error("load update entered without task read");

endmodule

// ===== rtl/schedule_load_spread.sv =====
// task-to-processor load balance evaluator
//
// input channel (in_valid_i / in_ready_o) takes one word per item: operation,
// task index, target processor and work time in unsigned 16.16. output channel
// (out_valid_o / out_ready_i) gives exactly one word per item: status and spread.
// the APB port holds procs_in_use at 0x0 and tasks_in_use at 0x4
//
// one item is in flight at a time, read-modify-write against the task memory
// and the per-processor load memory (both with synchronous reads):
//   rejected item, op 3, cached evaluate : straight to the result
//   load of a fresh task                 : task read, then add
//   reload or move of a loaded task      : task read, subtract, then add
//   evaluate with stale cache            : scan of the used processors (one read each)
// the result word sits in an output register, so a new item is accepted while
// the receiver stalls; the sequencer only waits if that register is still full
// after the next item is finished
//
// after reset a clearing pass over max(MAX_TASKS, MAX_PROCS) addresses (1024 at
// the default sizes) zeroes the loaded flags and processor totals; in_ready_o stays
// low until it is done, config writes are taken throughout
module schedule_load_spread #(
  parameter int MAX_TASKS = slsp_pkg::MAX_TASKS_DEF,
  parameter int MAX_PROCS = slsp_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = slsp_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [slsp_pkg::OP_W-1:0]     operation_i,
  input  logic [slsp_pkg::TIDX_W-1:0]   task_index_i,
  input  logic [slsp_pkg::PIDX_W-1:0]   target_proc_i,
  input  logic [slsp_pkg::WT_W-1:0]     work_time_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [slsp_pkg::ST_W-1:0]     status_o,
  output logic [slsp_pkg::LOAD_W-1:0]   spread_o
);

  slsp_pkg::cfg_t cfg;
  slsp_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  logic                         out_valid_q;
  logic [slsp_pkg::ST_W-1:0]    status_q;
  logic [slsp_pkg::LOAD_W-1:0]  spread_q;

  slsp_apb_regs #(
    .MAX_TASKS(MAX_TASKS),
    .MAX_PROCS(MAX_PROCS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  slsp_seq #(
    .MAX_TASKS(MAX_TASKS),
    .MAX_PROCS(MAX_PROCS),
    .TIME_BITS(TIME_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .task_index_i (task_index_i),
    .target_proc_i(target_proc_i),
    .work_time_i  (work_time_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register: refilled in the cycle the old word leaves
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      status_q <= res.status;
      spread_q <= res.spread;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign spread_o    = spread_q;

endmodule
